@@ src/zlhd_pkg.sv @@
package zlhd_pkg;

   localparam logic [31:0] LOCAL_MAGIC    = 32'h04034b50;
   localparam logic [7:0]  DESC_FLAG_MASK = 8'h08;
   localparam logic [31:0] DESC_LEN       = 32'd12;
   localparam logic [4:0]  HEADER_LAST    = 5'd29;

   localparam logic [1:0] KIND_NAME    = 2'd0;
   localparam logic [1:0] KIND_CONTENT = 2'd1;
   localparam logic [1:0] KIND_END     = 2'd2;
   localparam logic [1:0] KIND_STOP    = 2'd3;

   localparam logic [1:0] STATUS_STORED      = 2'd0;
   localparam logic [1:0] STATUS_LISTED      = 2'd1;
   localparam logic [1:0] STATUS_UNSUPPORTED = 2'd2;

   localparam logic [1:0] REASON_END        = 2'd0;
   localparam logic [1:0] REASON_BAD_SIG    = 2'd1;
   localparam logic [1:0] REASON_NAME_TRUNC = 2'd2;
   localparam logic [1:0] REASON_DATA_TRUNC = 2'd3;

   localparam int          CSR_ADDR_WIDTH = 3;
   localparam logic [2:0]  ADDR_LIST_ONLY = 3'd0;

   localparam int RSP_DATA_WIDTH = 96;

   // results caused by one request byte: an optional byte record, then an
   // optional entry end or stop record
   typedef struct packed {
      logic        a_valid;
      logic [1:0]  a_kind;
      logic [7:0]  a_byte;
      logic        b_valid;
      logic [1:0]  b_kind;
      logic [1:0]  b_status;
      logic [1:0]  b_reason;
      logic        b_carry;
      logic [15:0] method;
      logic [31:0] stored;
      logic [31:0] original;
   } pair_type;

endpackage

@@ src/zlhd_front.sv @@
module zlhd_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               list_only,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [7:0]         in_byte,
   input  logic               in_final,
   input  logic               space,
   output logic               push,
   output zlhd_pkg::pair_type push_data
);

   localparam logic [2:0] PH_HEADER  = 3'd0;
   localparam logic [2:0] PH_NAME    = 3'd1;
   localparam logic [2:0] PH_EXTRA   = 3'd2;
   localparam logic [2:0] PH_DATA    = 3'd3;
   localparam logic [2:0] PH_DESC    = 3'd4;
   localparam logic [2:0] PH_STOPPED = 3'd5;

   logic [2:0]  phase_ff, phase_in;
   logic [31:0] count_ff, count_in;
   logic [31:0] sig_ff, sig_in;
   logic        desc_ff, desc_in;
   logic [15:0] method_ff, method_in;
   logic [31:0] stored_ff, stored_in;
   logic [31:0] orig_ff, orig_in;
   logic [15:0] name_len_ff, name_len_in;
   logic [15:0] extra_len_ff, extra_len_in;

   logic        accept;
   logic [31:0] cnt_inc;
   logic        enter_req;
   logic [2:0]  enter_ph;
   logic        close_req;
   logic        closed;
   logic        stopped;
   zlhd_pkg::pair_type pair;

   assign in_ready = space;
   assign accept   = in_valid && space;
   assign cnt_inc  = count_ff + 32'd1;

   always_comb begin
      phase_in     = phase_ff;
      count_in     = count_ff;
      sig_in       = sig_ff;
      desc_in      = desc_ff;
      method_in    = method_ff;
      stored_in    = stored_ff;
      orig_in      = orig_ff;
      name_len_in  = name_len_ff;
      extra_len_in = extra_len_ff;
      enter_req    = 1'b0;
      enter_ph     = PH_NAME;
      close_req    = 1'b0;
      closed       = 1'b0;
      stopped      = 1'b0;
      pair         = '0;
      pair.a_kind  = zlhd_pkg::KIND_NAME;
      pair.a_byte  = in_byte;

      case (phase_ff)
         PH_HEADER: begin
            if (count_ff[4:0] == 5'd0) begin
               sig_in       = '0;
               desc_in      = 1'b0;
               method_in    = '0;
               stored_in    = '0;
               orig_in      = '0;
               name_len_in  = '0;
               extra_len_in = '0;
            end
            case (count_ff[4:0])
               5'd0:  sig_in[7:0]           = in_byte;
               5'd1:  sig_in[15:8]          = in_byte;
               5'd2:  sig_in[23:16]         = in_byte;
               5'd3:  sig_in[31:24]         = in_byte;
               5'd6:  desc_in = (in_byte & zlhd_pkg::DESC_FLAG_MASK) != 8'd0;
               5'd8:  method_in[7:0]        = in_byte;
               5'd9:  method_in[15:8]       = in_byte;
               5'd18: stored_in[7:0]        = in_byte;
               5'd19: stored_in[15:8]       = in_byte;
               5'd20: stored_in[23:16]      = in_byte;
               5'd21: stored_in[31:24]      = in_byte;
               5'd22: orig_in[7:0]          = in_byte;
               5'd23: orig_in[15:8]         = in_byte;
               5'd24: orig_in[23:16]        = in_byte;
               5'd25: orig_in[31:24]        = in_byte;
               5'd26: name_len_in[7:0]      = in_byte;
               5'd27: name_len_in[15:8]     = in_byte;
               5'd28: extra_len_in[7:0]     = in_byte;
               5'd29: extra_len_in[15:8]    = in_byte;
               default: ;
            endcase
            count_in = cnt_inc;
            if (count_ff[4:0] == zlhd_pkg::HEADER_LAST) begin
               if (sig_in != zlhd_pkg::LOCAL_MAGIC) begin
                  pair.b_valid  = 1'b1;
                  pair.b_kind   = zlhd_pkg::KIND_STOP;
                  pair.b_reason = zlhd_pkg::REASON_BAD_SIG;
                  phase_in      = PH_STOPPED;
                  count_in      = '0;
                  stopped       = 1'b1;
               end else begin
                  enter_req = 1'b1;
                  enter_ph  = PH_NAME;
               end
            end
         end
         PH_NAME: begin
            pair.a_valid = 1'b1;
            pair.a_kind  = zlhd_pkg::KIND_NAME;
            count_in     = cnt_inc;
            if (cnt_inc == {16'd0, name_len_ff}) begin
               enter_req = 1'b1;
               enter_ph  = PH_EXTRA;
            end
         end
         PH_EXTRA: begin
            count_in = cnt_inc;
            if (cnt_inc == {16'd0, extra_len_ff}) begin
               enter_req = 1'b1;
               enter_ph  = PH_DATA;
            end
         end
         PH_DATA: begin
            if (!list_only && method_ff == 16'd0) begin
               pair.a_valid = 1'b1;
               pair.a_kind  = zlhd_pkg::KIND_CONTENT;
            end
            count_in = cnt_inc;
            if (cnt_inc == stored_ff) close_req = 1'b1;
         end
         PH_DESC: begin
            count_in = cnt_inc;
            if (cnt_inc == zlhd_pkg::DESC_LEN) begin
               phase_in = PH_HEADER;
               count_in = '0;
            end
         end
         default: ;
      endcase

      if (enter_req) begin
         count_in = '0;
         if (enter_ph == PH_NAME && name_len_in == 16'd0) enter_ph = PH_EXTRA;
         if (enter_ph == PH_EXTRA && extra_len_in == 16'd0) enter_ph = PH_DATA;
         if (enter_ph == PH_DATA && stored_in == 32'd0) begin
            close_req = 1'b1;
         end else begin
            phase_in = enter_ph;
         end
      end

      if (close_req) begin
         pair.b_valid = 1'b1;
         pair.b_kind  = zlhd_pkg::KIND_END;
         pair.b_carry = 1'b1;
         if (list_only) begin
            pair.b_status = zlhd_pkg::STATUS_LISTED;
         end else if (method_in == 16'd0) begin
            pair.b_status = zlhd_pkg::STATUS_STORED;
         end else begin
            pair.b_status = zlhd_pkg::STATUS_UNSUPPORTED;
         end
         phase_in = desc_in ? PH_DESC : PH_HEADER;
         count_in = '0;
         closed   = 1'b1;
      end

      if (in_final && !closed && !stopped) begin
         pair.b_kind = zlhd_pkg::KIND_STOP;
         case (phase_in)
            PH_HEADER, PH_DESC: begin
               pair.b_valid  = 1'b1;
               pair.b_reason = zlhd_pkg::REASON_END;
            end
            PH_NAME: begin
               pair.b_valid  = 1'b1;
               pair.b_reason = zlhd_pkg::REASON_NAME_TRUNC;
               pair.b_carry  = 1'b1;
            end
            PH_EXTRA, PH_DATA: begin
               pair.b_valid  = 1'b1;
               pair.b_reason = zlhd_pkg::REASON_DATA_TRUNC;
               pair.b_carry  = 1'b1;
            end
            default: ;
         endcase
      end

      pair.method   = method_in;
      pair.stored   = stored_in;
      pair.original = orig_in;
   end

   assign push      = accept && (pair.a_valid || pair.b_valid);
   assign push_data = pair;

   always_ff @(posedge clock) begin
      if (reset || (accept && in_final)) begin
         phase_ff     <= PH_HEADER;
         count_ff     <= '0;
         sig_ff       <= '0;
         desc_ff      <= 1'b0;
         method_ff    <= '0;
         stored_ff    <= '0;
         orig_ff      <= '0;
         name_len_ff  <= '0;
         extra_len_ff <= '0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         sig_ff       <= sig_in;
         desc_ff      <= desc_in;
         method_ff    <= method_in;
         stored_ff    <= stored_in;
         orig_ff      <= orig_in;
         name_len_ff  <= name_len_in;
         extra_len_ff <= extra_len_in;
      end
   end

endmodule

@@ src/zlhd_back.sv @@
module zlhd_back #(
   parameter int DEPTH = 4
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  push,
   input  zlhd_pkg::pair_type                    push_data,
   output logic                                  space,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [zlhd_pkg::RSP_DATA_WIDTH-1:0]   rsp_tdata,
   output logic [1:0]                            rsp_tuser,
   output logic                                  rsp_tlast
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

   zlhd_pkg::pair_type queue_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          half_ff, half_in;

   logic                                valid_ff, valid_in;
   logic [zlhd_pkg::RSP_DATA_WIDTH-1:0] data_ff, data_in;
   logic [1:0]                          kind_ff, kind_in;
   logic                                last_ff, last_in;

   zlhd_pkg::pair_type head;
   logic head_valid;
   logic load;
   logic send_a;
   logic pop;
   logic carry;
   logic [7:0] rec_byte;
   logic [1:0] rec_status;
   logic [1:0] rec_reason;

   assign space      = count_ff != CW'(DEPTH);
   assign head_valid = count_ff != '0;
   assign head       = queue_ff[rd_ptr_ff];
   assign load       = head_valid && (!valid_ff || rsp_tready);
   assign send_a     = head.a_valid && !half_ff;
   assign pop        = load && !(send_a && head.b_valid);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PW'(1);
      if (pop) rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PW'(1);
      count_in = count_ff + CW'(push) - CW'(pop);
      half_in  = half_ff;
      if (load) half_in = send_a && head.b_valid;
   end

   always_comb begin
      kind_in    = send_a ? head.a_kind : head.b_kind;
      rec_byte   = send_a ? head.a_byte : 8'd0;
      rec_status = send_a ? 2'd0 : head.b_status;
      rec_reason = send_a ? 2'd0 : head.b_reason;
      carry      = send_a || head.b_carry;
      last_in    = !(send_a && head.b_valid);
      data_in    = {4'd0,
                    carry ? head.original : 32'd0,
                    carry ? head.stored : 32'd0,
                    carry ? head.method : 16'd0,
                    rec_reason, rec_status, rec_byte};
      valid_in   = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push) queue_ff[wr_ptr_ff] <= push_data;
      if (load) begin
         data_ff <= data_in;
         kind_ff <= kind_in;
         last_ff <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         half_ff   <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         half_ff   <= half_in;
         valid_ff  <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;

endmodule

@@ src/zip_local_header_deframer_core.sv @@
// Walks zip local entries in an archive that arrives one byte per request
// (tlast marks the archive's last byte). Each entry's 30-byte header is
// checked for the local signature; name bytes are passed on, and content
// bytes of stored entries are passed on unless list_only is set. Every complete
// entry closes with an entry end record and a stop record reports a clean end, a
// bad signature or truncation; after a stop, bytes up to the final one give
// nothing. The parser takes one byte per cycle and writes the one or two
// results of each byte into a queue of QUEUE_DEPTH requests; the output side
// sends one result per cycle while rsp_tready is high, so a byte that yields
// two results (a name or content byte that also closes an entry or ends the
// archive) goes out as two records, one that yields one as one record and
// one that yields none as nothing. The request side stalls only while the
// queue is full. Each result is held in the queue, then in the output register.
module zip_local_header_deframer_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // data_byte [7:0]
   input  logic [7:0]                            req_tdata,
   input  logic                                  req_tlast,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // byte_value [7:0], entry_status [9:8], stop_reason [11:10],
   // method_code [27:12], stored_size [59:28], original_size [91:60]
   output logic [zlhd_pkg::RSP_DATA_WIDTH-1:0]   rsp_tdata,
   // record_kind [1:0]
   output logic [1:0]                            rsp_tuser,
   output logic                                  rsp_tlast,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [zlhd_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  logic [31:0]                           csr_pwdata,
   output logic [31:0]                           csr_prdata,
   output logic                                  csr_pready
);

   logic list_only_ff, list_only_in;
   logic space;
   logic push;
   zlhd_pkg::pair_type push_data;

   assign csr_pready = 1'b1;

   always_comb begin
      list_only_in = list_only_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
          csr_paddr == zlhd_pkg::ADDR_LIST_ONLY) begin
         list_only_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         list_only_ff <= 1'b0;
      end else begin
         list_only_ff <= list_only_in;
      end
   end

   assign csr_prdata = (csr_paddr == zlhd_pkg::ADDR_LIST_ONLY) ?
                       {31'd0, list_only_ff} : 32'd0;

   zlhd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .list_only (list_only_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_byte   (req_tdata),
      .in_final  (req_tlast),
      .space     (space),
      .push      (push),
      .push_data (push_data)
   );

   zlhd_back #(
      .DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .space      (space),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

@@ test/zlhd_record_checker.sv @@
`timescale 1ns / 100ps

module zlhd_record_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [7:0]                          req_tdata,
   input  logic                                req_tlast,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [zlhd_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   input  logic [1:0]                          rsp_tuser,
   input  logic                                rsp_tlast,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [zlhd_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   input  logic                                csr_pready,
   output int                                  fail_count,
   output int                                  pending
);

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_NAME,
      PH_EXTRA,
      PH_DATA,
      PH_DESC,
      PH_STOPPED
   } phase_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  byte_value;
      logic [1:0]  status;
      logic [1:0]  reason;
      logic [15:0] method;
      logic [31:0] stored;
      logic [31:0] original;
      logic        last;
   } record_type;

   phase_type   phase;
   logic [31:0] count;
   logic [31:0] signature;
   logic        has_descriptor;
   logic [15:0] method_code;
   logic [31:0] stored_size;
   logic [31:0] original_size;
   logic [15:0] name_len;
   logic [15:0] extra_len;
   logic        list_only;
   logic        closed;
   int          mismatches = 0;

   record_type expected_records[$];
   record_type step_records[$];

   task automatic clear_parser();
      phase = PH_HEADER;
      count = '0;
      signature = '0;
      has_descriptor = 1'b0;
      method_code = '0;
      stored_size = '0;
      original_size = '0;
      name_len = '0;
      extra_len = '0;
   endtask

   task automatic emit(input logic [1:0] kind, input logic [7:0] b, input logic [1:0] status,
                       input logic [1:0] reason, input logic carry);
      record_type r;
      r.kind = kind;
      r.byte_value = b;
      r.status = status;
      r.reason = reason;
      r.method = carry ? method_code : '0;
      r.stored = carry ? stored_size : '0;
      r.original = carry ? original_size : '0;
      r.last = 1'b0;
      step_records.push_back(r);
   endtask

   task automatic close_entry();
      logic [1:0] status;
      if (list_only)
         status = zlhd_pkg::STATUS_LISTED;
      else if (method_code == 16'd0)
         status = zlhd_pkg::STATUS_STORED;
      else
         status = zlhd_pkg::STATUS_UNSUPPORTED;
      emit(zlhd_pkg::KIND_END, 8'd0, status, '0, 1'b1);
      phase = has_descriptor ? PH_DESC : PH_HEADER;
      count = '0;
      closed = 1'b1;
   endtask

   // skips empty name and extra fields, and an empty data field closes the entry
   task automatic enter_phase(input phase_type target);
      phase_type p;
      p = target;
      count = '0;
      if (p == PH_NAME && name_len == 16'd0) p = PH_EXTRA;
      if (p == PH_EXTRA && extra_len == 16'd0) p = PH_DATA;
      if (p == PH_DATA && stored_size == 32'd0)
         close_entry();
      else
         phase = p;
   endtask

   task automatic parse_byte(input logic [7:0] b, input logic fin);
      logic       stopped;
      int         idx;
      record_type r;
      stopped = 1'b0;
      closed = 1'b0;
      step_records.delete();
      case (phase)
         PH_HEADER: begin
            idx = count;
            if (idx == 0) begin
               signature = '0;
               has_descriptor = 1'b0;
               method_code = '0;
               stored_size = '0;
               original_size = '0;
               name_len = '0;
               extra_len = '0;
            end
            if (idx < 4)
               signature[8*idx +: 8] = b;
            else if (idx == 6)
               has_descriptor = |(b & zlhd_pkg::DESC_FLAG_MASK);
            else if (idx == 8 || idx == 9)
               method_code[8*(idx-8) +: 8] = b;
            else if (idx >= 18 && idx < 22)
               stored_size[8*(idx-18) +: 8] = b;
            else if (idx >= 22 && idx < 26)
               original_size[8*(idx-22) +: 8] = b;
            else if (idx == 26 || idx == 27)
               name_len[8*(idx-26) +: 8] = b;
            else if (idx == 28 || idx == 29)
               extra_len[8*(idx-28) +: 8] = b;
            count = count + 32'd1;
            if (count > 32'(zlhd_pkg::HEADER_LAST)) begin
               if (signature != zlhd_pkg::LOCAL_MAGIC) begin
                  emit(zlhd_pkg::KIND_STOP, 8'd0, '0, zlhd_pkg::REASON_BAD_SIG, 1'b0);
                  phase = PH_STOPPED;
                  count = '0;
                  stopped = 1'b1;
               end else begin
                  enter_phase(PH_NAME);
               end
            end
         end
         PH_NAME: begin
            emit(zlhd_pkg::KIND_NAME, b, '0, '0, 1'b1);
            count = count + 32'd1;
            if (count >= 32'(name_len)) enter_phase(PH_EXTRA);
         end
         PH_EXTRA: begin
            count = count + 32'd1;
            if (count >= 32'(extra_len)) enter_phase(PH_DATA);
         end
         PH_DATA: begin
            if (!list_only && method_code == 16'd0)
               emit(zlhd_pkg::KIND_CONTENT, b, '0, '0, 1'b1);
            count = count + 32'd1;
            if (count >= stored_size) close_entry();
         end
         PH_DESC: begin
            count = count + 32'd1;
            if (count >= zlhd_pkg::DESC_LEN) begin
               phase = PH_HEADER;
               count = '0;
            end
         end
         default: ;
      endcase

      if (fin) begin
         if (!closed && !stopped) begin
            if (phase == PH_HEADER || phase == PH_DESC)
               emit(zlhd_pkg::KIND_STOP, 8'd0, '0, zlhd_pkg::REASON_END, 1'b0);
            else if (phase == PH_NAME)
               emit(zlhd_pkg::KIND_STOP, 8'd0, '0, zlhd_pkg::REASON_NAME_TRUNC, 1'b1);
            else if (phase == PH_EXTRA || phase == PH_DATA)
               emit(zlhd_pkg::KIND_STOP, 8'd0, '0, zlhd_pkg::REASON_DATA_TRUNC, 1'b1);
         end
         clear_parser();
      end

      if (step_records.size() > 0) begin
         r = step_records.pop_back();
         r.last = 1'b1;
         step_records.push_back(r);
      end
      while (step_records.size() > 0) expected_records.push_back(step_records.pop_front());
   endtask

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      record_type want;
      if (reset) begin
         clear_parser();
         list_only = 1'b0;
         expected_records.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_records.size() == 0) begin
               $error("record_kind: expected nothing, got 0x%0h", rsp_tuser);
               mismatches++;
            end else begin
               want = expected_records.pop_front();
               check_field("record_kind", 32'(want.kind), 32'(rsp_tuser));
               check_field("byte_value", 32'(want.byte_value), 32'(rsp_tdata[7:0]));
               check_field("entry_status", 32'(want.status), 32'(rsp_tdata[9:8]));
               check_field("stop_reason", 32'(want.reason), 32'(rsp_tdata[11:10]));
               check_field("method_code", 32'(want.method), 32'(rsp_tdata[27:12]));
               check_field("stored_size", want.stored, rsp_tdata[59:28]);
               check_field("original_size", want.original, rsp_tdata[91:60]);
               check_field("last_of_run", 32'(want.last), 32'(rsp_tlast));
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr == zlhd_pkg::ADDR_LIST_ONLY)
            list_only = csr_pwdata[0];
         if (req_tvalid && req_tready) parse_byte(req_tdata, req_tlast);
      end
      fail_count <= mismatches;
      pending <= expected_records.size();
   end

endmodule

@@ test/zip_local_header_deframer_core_tb.sv @@
`timescale 1ns / 100ps

module zip_local_header_deframer_core_tb;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic [7:0]                          req_tdata = '0;
   logic                                req_tlast = 1'b0;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [zlhd_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic [1:0]                          rsp_tuser;
   logic                                rsp_tlast;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic                                csr_psel = 1'b0;
   logic                                csr_penable = 1'b0;
   logic                                csr_pwrite = 1'b0;
   logic [zlhd_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [31:0]                         csr_pwdata = '0;
   logic [31:0]                         csr_prdata;
   logic                                csr_pready;

   int   fail_count;
   int   pending;
   logic hold_ask = 1'b0;

   // {final flag, archive byte}
   logic [8:0] archive_q[$];
   int         ignored_bytes;

   always #5 clock = ~clock;

   zip_local_header_deframer_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   zlhd_record_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // result side: random stalls in stretches, plus one long hold-off on request
   initial begin : result_sink
      int   stall;
      logic idle;
      logic held;
      stall = 0;
      idle = 1'b1;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            if ($urandom_range(0, 15) == 0) idle = !idle;
            stall = idle ? $urandom_range(0, 11) : 0;
         end else if (stall > 0) begin
            stall = stall - 1;
         end
         if (hold_ask && !held) begin
            held = 1'b1;
            stall = 150;
         end
         rsp_tready <= (stall == 0);
      end
   end

   task automatic put_le(input logic [31:0] v, input int n);
      for (int i = 0; i < n; i++) archive_q.push_back({1'b0, v[8*i +: 8]});
   endtask

   task automatic put_random(input int n);
      for (int i = 0; i < n; i++) archive_q.push_back({1'b0, 8'($urandom)});
   endtask

   task automatic put_header(input logic [31:0] sig, input logic [15:0] flags,
                             input logic [15:0] method, input logic [31:0] stored,
                             input logic [31:0] original, input logic [15:0] nlen,
                             input logic [15:0] xlen);
      put_le(sig, 4);
      put_random(2);
      put_le(32'(flags), 2);
      put_le(32'(method), 2);
      put_random(8);
      put_le(stored, 4);
      put_le(original, 4);
      put_le(32'(nlen), 2);
      put_le(32'(xlen), 2);
   endtask

   task automatic mark_final();
      logic [8:0] item;
      item = archive_q.pop_back();
      archive_q.push_back({1'b1, item[7:0]});
   endtask

   task automatic put_random_archive();
      int          start;
      int          entries;
      int          keep;
      int          tail;
      logic [31:0] sig;
      logic [15:0] flags;
      logic [15:0] method;
      logic [31:0] stored;
      logic [15:0] nlen;
      logic [15:0] xlen;
      logic        ended;
      logic [8:0]  item;
      start = archive_q.size();
      entries = $urandom_range(1, 3);
      ended = 1'b0;
      for (int e = 0; e < entries && !ended; e++) begin
         case ($urandom_range(0, 11))
            0: sig = $urandom;
            1: sig = zlhd_pkg::LOCAL_MAGIC ^ (32'd1 << $urandom_range(0, 31));
            default: sig = zlhd_pkg::LOCAL_MAGIC;
         endcase
         flags = 16'($urandom);
         case ($urandom_range(0, 3))
            2: method = 16'd8;
            3: method = 16'($urandom);
            default: method = 16'd0;
         endcase
         stored = $urandom_range(0, 6);
         nlen = 16'($urandom_range(0, 4));
         xlen = 16'($urandom_range(0, 3));
         if ($urandom_range(0, 15) == 0) begin
            // oversized field; with a good signature the archive is cut inside the entry
            case ($urandom_range(0, 2))
               0: nlen = 16'($urandom_range(16, 65535));
               1: xlen = 16'($urandom_range(16, 65535));
               default: stored = $urandom | 32'h0001_0000;
            endcase
            put_header(sig, flags, method, stored, $urandom, nlen, xlen);
            if (sig == zlhd_pkg::LOCAL_MAGIC) begin
               put_random($urandom_range(1, 8));
               ended = 1'b1;
            end
         end else begin
            put_header(sig, flags, method, stored, $urandom, nlen, xlen);
         end
         if (sig != zlhd_pkg::LOCAL_MAGIC) begin
            tail = $urandom_range(0, 4);
            put_random(tail);
            ignored_bytes += tail;
            ended = 1'b1;
         end else if (!ended) begin
            put_random(int'(nlen) + int'(xlen) + int'(stored));
            if (flags[3]) put_random(int'(zlhd_pkg::DESC_LEN));
         end
      end
      if (!ended && $urandom_range(0, 3) == 0) put_random($urandom_range(1, 29));
      if ($urandom_range(0, 4) == 0) begin
         keep = $urandom_range(1, archive_q.size() - start);
         while (archive_q.size() > start + keep) item = archive_q.pop_back();
      end
      mark_final();
   endtask

   task automatic send_archive();
      logic [8:0] item;
      int         gap;
      logic       idle;
      idle = 1'($urandom_range(0, 1));
      while (archive_q.size() > 0) begin
         item = archive_q.pop_front();
         if ($urandom_range(0, 31) == 0) idle = !idle;
         gap = idle ? $urandom_range(0, 11) : 0;
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_tdata <= item[7:0];
         req_tlast <= item[8];
         req_tvalid <= 1'b1;
         @(posedge clock);
         while (!req_tready) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic csr_write(input logic [zlhd_pkg::CSR_ADDR_WIDTH-1:0] addr,
                            input logic [31:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   initial begin
      int sent;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      csr_write(zlhd_pkg::ADDR_LIST_ONLY, 32'd0);

      // lone final byte inside a header
      put_le(32'h50, 1);
      mark_final();
      // stored entry closed by the final byte
      put_header(zlhd_pkg::LOCAL_MAGIC, 16'h0000, 16'd0, 32'd3, 32'd3, 16'd2, 16'd1);
      put_le(32'h0000FF00, 2);
      put_random(1);
      put_le(32'h005AFF00, 3);
      mark_final();
      // deflated entry with descriptor, then an empty entry closed by the final byte
      put_header(zlhd_pkg::LOCAL_MAGIC, 16'h0008, 16'd8, 32'd2, 32'hFFFF_FFFF, 16'd1, 16'd0);
      put_random(1 + 2 + int'(zlhd_pkg::DESC_LEN));
      put_header(zlhd_pkg::LOCAL_MAGIC, 16'hFFF7, 16'hFFFF, 32'd0, 32'd0, 16'd0, 16'd0);
      mark_final();
      // final byte inside a descriptor
      put_header(zlhd_pkg::LOCAL_MAGIC, 16'hFFFF, 16'd0, 32'd1, 32'd1, 16'd0, 16'd0);
      put_random(1 + 5);
      mark_final();
      // final byte on the last descriptor byte
      put_header(zlhd_pkg::LOCAL_MAGIC, 16'h0008, 16'd0, 32'd1, 32'd1, 16'd0, 16'd2);
      put_random(2 + 1 + int'(zlhd_pkg::DESC_LEN));
      mark_final();
      // bad signature, ignored tail
      put_header(32'hFFFF_FFFF, 16'd0, 16'd0, 32'd1, 32'd1, 16'd1, 16'd0);
      put_random(4);
      mark_final();
      // bad signature on the final byte
      put_header(32'h0000_0000, 16'd0, 16'd0, 32'd0, 32'd0, 16'd0, 16'd0);
      mark_final();
      // name truncated
      put_header(zlhd_pkg::LOCAL_MAGIC, 16'd0, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 16'hFFFF, 16'd0);
      put_random(3);
      mark_final();
      // extra field truncated
      put_header(zlhd_pkg::LOCAL_MAGIC, 16'd0, 16'd0, 32'd4, 32'd0, 16'd0, 16'hFFFF);
      put_random(2);
      mark_final();
      // data truncated
      put_header(zlhd_pkg::LOCAL_MAGIC, 16'd0, 16'd0, 32'hFFFF_FFFF, 32'd7, 16'd1, 16'd0);
      put_random(3);
      mark_final();
      // complete entry, then a short header tail
      put_header(zlhd_pkg::LOCAL_MAGIC, 16'd0, 16'd0, 32'd1, 32'd1, 16'd1, 16'd0);
      put_random(2 + 10);
      mark_final();
      send_archive();
      drain();

      csr_write(zlhd_pkg::ADDR_LIST_ONLY, 32'd1);
      put_header(zlhd_pkg::LOCAL_MAGIC, 16'd0, 16'd0, 32'd2, 32'd2, 16'd1, 16'd0);
      put_random(3);
      put_header(zlhd_pkg::LOCAL_MAGIC, 16'd0, 16'd12, 32'd2, 32'd9, 16'd0, 16'd0);
      put_random(2);
      mark_final();
      send_archive();
      drain();

      for (int p = 0; p < 2; p++) begin
         csr_write(zlhd_pkg::ADDR_LIST_ONLY, (p == 1) ? 32'd1 : 32'd0);
         ignored_bytes = 0;
         sent = 0;
         while (sent < 40) begin
            put_random_archive();
            sent = archive_q.size() - ignored_bytes;
         end
         if (p == 1) hold_ask <= 1'b1;
         send_archive();
         drain();
      end

      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
